// File: rtl/core/bsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_pkg: shared definitions for the safe allocation engine
// Sizes, operation and status codes, row types and the control state type.
// ----------------------------------------------------------------------------
package bsa_pkg;

   localparam int PROCESSES = 8;
   localparam int RESOURCES = 4;
   localparam int PIDX_W    = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
   localparam int AMT_W     = 8;
   localparam int WORK_W    = 12;
   localparam int NEED_W    = AMT_W + 2;
   localparam int SLOT_W    = 3;
   localparam int SLOTS     = 8;
   localparam int CNT_W     = 4;

   localparam logic [2:0] OP_LOAD_MAX   = 3'd0;
   localparam logic [2:0] OP_LOAD_ALLOC = 3'd1;
   localparam logic [2:0] OP_LOAD_AVAIL = 3'd2;
   localparam logic [2:0] OP_REQUEST    = 3'd3;
   localparam logic [2:0] OP_CHECK      = 3'd4;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_OVER_NEED  = 2'd1;
   localparam logic [1:0] ST_OVER_AVAIL = 2'd2;
   localparam logic [1:0] ST_UNSAFE     = 2'd3;

   typedef logic [RESOURCES-1:0][AMT_W-1:0]  amt_row_type;
   typedef logic [RESOURCES-1:0][WORK_W-1:0] work_row_type;

   // Result of comparing one process row against a request and a work vector.
   typedef struct packed {
      logic fits;
      logic over_need;
   } row_chk_type;

   typedef enum logic [5:0] {
      FSM_IDLE    = 6'b000001,
      FSM_READ    = 6'b000010,
      FSM_CHECK   = 6'b000100,
      FSM_SCAN_RD = 6'b001000,
      FSM_SCAN_EV = 6'b010000,
      FSM_FINISH  = 6'b100000
   } fsm_type;

endpackage

// File: rtl/core/bsa_row_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_row_check: need comparison for one process row
// Forms the signed need of every resource and compares it with a request
// and with the work vector of the safety scan.
// ----------------------------------------------------------------------------
module bsa_row_check (
   input  bsa_pkg::amt_row_type  max_row,
   input  bsa_pkg::amt_row_type  alloc_row,
   input  bsa_pkg::amt_row_type  amt_row,
   input  bsa_pkg::work_row_type work_row,
   output bsa_pkg::row_chk_type  chk
);

   logic signed [bsa_pkg::NEED_W-1:0]   need [bsa_pkg::RESOURCES];
   logic signed [bsa_pkg::WORK_W:0]     need_x [bsa_pkg::RESOURCES];

   always_comb begin
      chk.fits      = 1'b1;
      chk.over_need = 1'b0;
      for (int r = 0; r < bsa_pkg::RESOURCES; r++) begin
         need[r] = $signed({2'b00, max_row[r]}) - $signed({2'b00, alloc_row[r]});
         need_x[r] = {{(bsa_pkg::WORK_W + 1 - bsa_pkg::NEED_W){need[r][bsa_pkg::NEED_W-1]}},
                      need[r]};
         // Negative need fits any work amount and rejects any request.
         if (need_x[r] > $signed({1'b0, work_row[r]})) begin
            chk.fits = 1'b0;
         end
         if ($signed({2'b00, amt_row[r]}) > need[r]) begin
            chk.over_need = 1'b1;
         end
      end
   end

endmodule

// File: rtl/core/banker_safe_allocation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banker_safe_allocation: deadlock avoidance engine
// Holds claim and allocation tables and runs the safety scan on request.
// ----------------------------------------------------------------------------
// Each request beat yields exactly one response beat; a load goes straight
// to the finish state. A request reads its process row, checks it, and then
// runs the safety scan, which like a plain check reads each process row in
// the scan read state and evaluates it in the scan evaluate state, through
// the registered read port of the row memories. Each round of the scan
// restarts at process zero and stops at the first process it can finish, so
// for eight processes the scan visits at most 43 rows (seven rounds that
// finish the processes from the top down, then a last round that finds
// none). The claim and allocation tables live in row-wide memories, one row
// per process, with a valid bit per row so that rows never loaded read as
// zero after reset. A request that passes the need and available checks is
// applied before the scan; if the scan finds the state unsafe, the saved
// allocation row and available vector are written back. A new request beat
// is taken only once the previous one is done, while its response may wait.
// ----------------------------------------------------------------------------
module banker_safe_allocation (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_op,
   input  logic [2:0]  req_process,
   input  logic [7:0]  req_amount_0,
   input  logic [7:0]  req_amount_1,
   input  logic [7:0]  req_amount_2,
   input  logic [7:0]  req_amount_3,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [23:0] rsp_safe_order,
   output logic [3:0]  rsp_order_length
);

   localparam int P  = bsa_pkg::PROCESSES;
   localparam int R  = bsa_pkg::RESOURCES;
   localparam int PW = bsa_pkg::PIDX_W;
   localparam int AW = bsa_pkg::AMT_W;
   localparam int WW = bsa_pkg::WORK_W;

   // Row memories: one row per process, all resources side by side.
   bsa_pkg::amt_row_type max_mem   [P];
   bsa_pkg::amt_row_type alloc_mem [P];

   bsa_pkg::fsm_type      state_ff, state_in;
   logic [P-1:0]          max_vld_ff, max_vld_in;
   logic [P-1:0]          alloc_vld_ff, alloc_vld_in;
   bsa_pkg::amt_row_type  avail_ff, avail_in;
   bsa_pkg::amt_row_type  rd_max_ff, rd_alloc_ff;
   logic                  rd_max_vld_ff, rd_alloc_vld_ff;
   logic [2:0]            op_ff, op_in;
   logic [PW-1:0]         proc_ff, proc_in;
   bsa_pkg::amt_row_type  amt_ff, amt_in;
   bsa_pkg::amt_row_type  save_alloc_ff, save_alloc_in;
   bsa_pkg::amt_row_type  save_avail_ff, save_avail_in;
   bsa_pkg::work_row_type work_ff, work_in;
   logic [P-1:0]          done_ff, done_in;
   logic [PW-1:0]         scan_p_ff, scan_p_in;
   logic [3:0]            cnt_ff, cnt_in;
   logic [23:0]           order_ff, order_in;
   logic [1:0]            status_ff, status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [23:0]           rsp_order_ff, rsp_order_in;
   logic [3:0]            rsp_len_ff, rsp_len_in;

   logic                  accept;
   logic                  proc_ok;
   logic [PW-1:0]         rd_addr;
   logic                  max_wr_en, alloc_wr_en;
   logic [PW-1:0]         max_wr_addr, alloc_wr_addr;
   bsa_pkg::amt_row_type  max_wr_data, alloc_wr_data;
   bsa_pkg::amt_row_type  port_amt;
   bsa_pkg::amt_row_type  max_row, alloc_row;
   bsa_pkg::work_row_type chk_work;
   bsa_pkg::row_chk_type  chk;
   logic                  over_avail;
   bsa_pkg::amt_row_type  applied_alloc, applied_avail;
   logic                  out_free;

   assign req_ready        = (state_ff == bsa_pkg::FSM_IDLE);
   assign accept           = req_valid & req_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_safe_order   = rsp_order_ff;
   assign rsp_order_length = rsp_len_ff;
   assign out_free         = ~rsp_valid_ff | rsp_ready;
   assign proc_ok          = ({1'b0, req_process} < 4'(P));
   assign rd_addr          = (state_ff == bsa_pkg::FSM_READ) ? proc_ff : scan_p_ff;

   // Only the first R amount ports carry resource types.
   always_comb begin
      logic [3:0][AW-1:0] ports;
      ports = {req_amount_3, req_amount_2, req_amount_1, req_amount_0};
      for (int r = 0; r < R; r++) begin
         port_amt[r] = ports[r];
      end
   end

   // Rows that were never loaded read as zero.
   always_comb begin
      max_row   = rd_max_vld_ff   ? rd_max_ff   : '0;
      alloc_row = rd_alloc_vld_ff ? rd_alloc_ff : '0;
   end

   always_comb begin
      for (int r = 0; r < R; r++) begin
         chk_work[r]      = (state_ff == bsa_pkg::FSM_SCAN_EV) ?
                            work_ff[r] : WW'(avail_ff[r]);
         applied_alloc[r] = alloc_row[r] + amt_ff[r];
         applied_avail[r] = avail_ff[r] - amt_ff[r];
      end
      over_avail = 1'b0;
      for (int r = 0; r < R; r++) begin
         if (amt_ff[r] > avail_ff[r]) begin
            over_avail = 1'b1;
         end
      end
   end

   bsa_row_check u_row_check (
      .max_row   (max_row),
      .alloc_row (alloc_row),
      .amt_row   (amt_ff),
      .work_row  (chk_work),
      .chk       (chk)
   );

   always_comb begin
      state_in      = state_ff;
      max_vld_in    = max_vld_ff;
      alloc_vld_in  = alloc_vld_ff;
      avail_in      = avail_ff;
      op_in         = op_ff;
      proc_in       = proc_ff;
      amt_in        = amt_ff;
      save_alloc_in = save_alloc_ff;
      save_avail_in = save_avail_ff;
      work_in       = work_ff;
      done_in       = done_ff;
      scan_p_in     = scan_p_ff;
      cnt_in        = cnt_ff;
      order_in      = order_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_order_in  = rsp_order_ff;
      rsp_len_in    = rsp_len_ff;
      max_wr_en     = 1'b0;
      max_wr_addr   = req_process[PW-1:0];
      max_wr_data   = port_amt;
      alloc_wr_en   = 1'b0;
      alloc_wr_addr = proc_ff;
      alloc_wr_data = port_amt;

      unique case (state_ff)
         bsa_pkg::FSM_IDLE: begin
            if (accept) begin
               op_in     = req_op;
               proc_in   = req_process[PW-1:0];
               amt_in    = port_amt;
               status_in = bsa_pkg::ST_OK;
               cnt_in    = '0;
               order_in  = '0;
               state_in  = bsa_pkg::FSM_FINISH;
               // Loads and unused op codes complete here; requests and checks move on.
               unique case (req_op)
                  bsa_pkg::OP_LOAD_MAX: begin
                     if (proc_ok) begin
                        max_wr_en                           = 1'b1;
                        max_vld_in[req_process[PW-1:0]]     = 1'b1;
                     end
                  end
                  bsa_pkg::OP_LOAD_ALLOC: begin
                     if (proc_ok) begin
                        alloc_wr_en                         = 1'b1;
                        alloc_wr_addr                       = req_process[PW-1:0];
                        alloc_vld_in[req_process[PW-1:0]]   = 1'b1;
                     end
                  end
                  bsa_pkg::OP_LOAD_AVAIL: begin
                     avail_in = port_amt;
                  end
                  bsa_pkg::OP_REQUEST: begin
                     if (proc_ok) begin
                        state_in = bsa_pkg::FSM_READ;
                     end
                  end
                  bsa_pkg::OP_CHECK: begin
                     for (int r = 0; r < R; r++) begin
                        work_in[r] = WW'(avail_ff[r]);
                     end
                     done_in   = '0;
                     scan_p_in = '0;
                     state_in  = bsa_pkg::FSM_SCAN_RD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         bsa_pkg::FSM_READ: begin
            state_in = bsa_pkg::FSM_CHECK;
         end
         bsa_pkg::FSM_CHECK: begin
            if (chk.over_need) begin
               status_in = bsa_pkg::ST_OVER_NEED;
               state_in  = bsa_pkg::FSM_FINISH;
            end else if (over_avail) begin
               status_in = bsa_pkg::ST_OVER_AVAIL;
               state_in  = bsa_pkg::FSM_FINISH;
            end else begin
               // Apply the request tentatively and keep what it replaced.
               save_alloc_in          = alloc_row;
               save_avail_in          = avail_ff;
               alloc_wr_en            = 1'b1;
               alloc_wr_data          = applied_alloc;
               alloc_vld_in[proc_ff]  = 1'b1;
               avail_in               = applied_avail;
               for (int r = 0; r < R; r++) begin
                  work_in[r] = WW'(applied_avail[r]);
               end
               done_in   = '0;
               scan_p_in = '0;
               state_in  = bsa_pkg::FSM_SCAN_RD;
            end
         end
         bsa_pkg::FSM_SCAN_RD: begin
            state_in = bsa_pkg::FSM_SCAN_EV;
         end
         bsa_pkg::FSM_SCAN_EV: begin
            if (!done_ff[scan_p_ff] && chk.fits) begin
               for (int r = 0; r < R; r++) begin
                  work_in[r] = work_ff[r] + WW'(alloc_row[r]);
               end
               done_in[scan_p_ff] = 1'b1;
               for (int s = 0; s < bsa_pkg::SLOTS; s++) begin
                  if (cnt_ff == 4'(s)) begin
                     order_in[s*bsa_pkg::SLOT_W +: bsa_pkg::SLOT_W] =
                        bsa_pkg::SLOT_W'(scan_p_ff);
                  end
               end
               cnt_in    = cnt_ff + 4'd1;
               scan_p_in = '0;
               if (cnt_ff + 4'd1 == 4'(P)) begin
                  status_in = bsa_pkg::ST_OK;
                  state_in  = bsa_pkg::FSM_FINISH;
               end else begin
                  state_in  = bsa_pkg::FSM_SCAN_RD;
               end
            end else if ({1'b0, scan_p_ff} == (PW + 1)'(P - 1)) begin
               // A full pass found no process to finish: unsafe.
               status_in = bsa_pkg::ST_UNSAFE;
               state_in  = bsa_pkg::FSM_FINISH;
               if (op_ff == bsa_pkg::OP_REQUEST) begin
                  alloc_wr_en   = 1'b1;
                  alloc_wr_data = save_alloc_ff;
                  avail_in      = save_avail_ff;
               end
            end else begin
               scan_p_in = scan_p_ff + PW'(1);
               state_in  = bsa_pkg::FSM_SCAN_RD;
            end
         end
         bsa_pkg::FSM_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_order_in  = order_ff;
               rsp_len_in    = cnt_ff;
               state_in      = bsa_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = bsa_pkg::FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (max_wr_en) begin
         max_mem[max_wr_addr] <= max_wr_data;
      end
      if (alloc_wr_en) begin
         alloc_mem[alloc_wr_addr] <= alloc_wr_data;
      end
      rd_max_ff       <= max_mem[rd_addr];
      rd_alloc_ff     <= alloc_mem[rd_addr];
      rd_max_vld_ff   <= max_vld_ff[rd_addr];
      rd_alloc_vld_ff <= alloc_vld_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsa_pkg::FSM_IDLE;
         max_vld_ff   <= '0;
         alloc_vld_ff <= '0;
         avail_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         max_vld_ff   <= max_vld_in;
         alloc_vld_ff <= alloc_vld_in;
         avail_ff     <= avail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      proc_ff       <= proc_in;
      amt_ff        <= amt_in;
      save_alloc_ff <= save_alloc_in;
      save_avail_ff <= save_avail_in;
      work_ff       <= work_in;
      done_ff       <= done_in;
      scan_p_ff     <= scan_p_in;
      cnt_ff        <= cnt_in;
      order_ff      <= order_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_order_ff  <= rsp_order_in;
      rsp_len_ff    <= rsp_len_in;
   end

endmodule

// File: bench/banker_safe_allocation_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banker_safe_allocation_chk: response checker for the safe allocation engine
// Mirrors the claim, allocation and available state, predicts every response
// beat from the accepted request beats and compares it field by field.
// ----------------------------------------------------------------------------
module banker_safe_allocation_chk (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_op,
   input  logic [2:0]  req_process,
   input  logic [7:0]  req_amount_0,
   input  logic [7:0]  req_amount_1,
   input  logic [7:0]  req_amount_2,
   input  logic [7:0]  req_amount_3,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_status,
   input  logic [23:0] rsp_safe_order,
   input  logic [3:0]  rsp_order_length,
   output int          error_count,
   output int          pending_count,
   output int          unsafe_seen,
   output int          granted_seen
);

   typedef struct packed {
      logic [1:0]  status;
      logic [23:0] order;
      logic [3:0]  length;
   } alloc_result_type;

   logic [7:0] claim_mem [bsa_pkg::PROCESSES][bsa_pkg::RESOURCES];
   logic [7:0] held_mem  [bsa_pkg::PROCESSES][bsa_pkg::RESOURCES];
   logic [7:0] free_vec  [bsa_pkg::RESOURCES];
   alloc_result_type expected_q [$];

   // Runs the scan over the mirrored state; returns 1 when all finish.
   function automatic logic run_scan(output logic [23:0] order, output logic [3:0] count);
      logic [11:0] work [bsa_pkg::RESOURCES];
      logic        done [bsa_pkg::PROCESSES];
      int          pick;
      logic        fits;
      order = '0;
      count = '0;
      for (int r = 0; r < bsa_pkg::RESOURCES; r++) work[r] = 12'(free_vec[r]);
      for (int p = 0; p < bsa_pkg::PROCESSES; p++) done[p] = 1'b0;
      for (int round = 0; round < bsa_pkg::PROCESSES; round++) begin
         pick = -1;
         for (int p = 0; p < bsa_pkg::PROCESSES && pick < 0; p++) begin
            if (!done[p]) begin
               fits = 1'b1;
               for (int r = 0; r < bsa_pkg::RESOURCES; r++)
                  if (int'(claim_mem[p][r]) - int'(held_mem[p][r]) > int'(work[r]))
                     fits = 1'b0;
               if (fits) pick = p;
            end
         end
         if (pick < 0) break;
         for (int r = 0; r < bsa_pkg::RESOURCES; r++) work[r] += 12'(held_mem[pick][r]);
         done[pick] = 1'b1;
         order |= 24'(pick) << (bsa_pkg::SLOT_W * count);
         count++;
      end
      return count == bsa_pkg::PROCESSES;
   endfunction

   function automatic alloc_result_type predict_allocation(logic [2:0] op, logic [2:0] pid,
                                                           logic [7:0] amt [bsa_pkg::RESOURCES]);
      alloc_result_type res;
      logic [7:0] save_free [bsa_pkg::RESOURCES];
      logic [7:0] save_held [bsa_pkg::RESOURCES];
      res = '0;
      unique case (op)
         bsa_pkg::OP_LOAD_MAX: begin
            for (int r = 0; r < bsa_pkg::RESOURCES; r++) claim_mem[pid][r] = amt[r];
         end
         bsa_pkg::OP_LOAD_ALLOC: begin
            for (int r = 0; r < bsa_pkg::RESOURCES; r++) held_mem[pid][r] = amt[r];
         end
         bsa_pkg::OP_LOAD_AVAIL: begin
            for (int r = 0; r < bsa_pkg::RESOURCES; r++) free_vec[r] = amt[r];
         end
         bsa_pkg::OP_REQUEST: begin
            for (int r = 0; r < bsa_pkg::RESOURCES; r++)
               if (int'(amt[r]) > int'(claim_mem[pid][r]) - int'(held_mem[pid][r]))
                  res.status = bsa_pkg::ST_OVER_NEED;
            if (res.status == bsa_pkg::ST_OK)
               for (int r = 0; r < bsa_pkg::RESOURCES; r++)
                  if (amt[r] > free_vec[r]) res.status = bsa_pkg::ST_OVER_AVAIL;
            if (res.status == bsa_pkg::ST_OK) begin
               for (int r = 0; r < bsa_pkg::RESOURCES; r++) begin
                  save_free[r] = free_vec[r];
                  save_held[r] = held_mem[pid][r];
                  free_vec[r] = free_vec[r] - amt[r];
                  held_mem[pid][r] = held_mem[pid][r] + amt[r];
               end
               if (!run_scan(res.order, res.length)) begin
                  res.status = bsa_pkg::ST_UNSAFE;
                  for (int r = 0; r < bsa_pkg::RESOURCES; r++) begin
                     free_vec[r] = save_free[r];
                     held_mem[pid][r] = save_held[r];
                  end
               end
            end
         end
         bsa_pkg::OP_CHECK: begin
            if (!run_scan(res.order, res.length)) res.status = bsa_pkg::ST_UNSAFE;
         end
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      logic [7:0] amt [bsa_pkg::RESOURCES];
      alloc_result_type want;
      if (reset) begin
         for (int p = 0; p < bsa_pkg::PROCESSES; p++)
            for (int r = 0; r < bsa_pkg::RESOURCES; r++) begin
               claim_mem[p][r] = '0;
               held_mem[p][r]  = '0;
            end
         for (int r = 0; r < bsa_pkg::RESOURCES; r++) free_vec[r] = '0;
         expected_q.delete();
         error_count   <= 0;
         unsafe_seen   <= 0;
         granted_seen  <= 0;
         pending_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               if (error_count < 10)
                  $display("%0t: response beat with nothing expected", $realtime);
               error_count <= error_count + 1;
            end else begin
               want = expected_q.pop_front();
               if (want != {rsp_status, rsp_safe_order, rsp_order_length}) begin
                  if (error_count < 10)
                     $display("%0t: mismatch exp st=%0d ord=%h len=%0d got st=%0d ord=%h len=%0d",
                              $realtime, want.status, want.order, want.length,
                              rsp_status, rsp_safe_order, rsp_order_length);
                  error_count <= error_count + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            amt[0] = req_amount_0;
            amt[1] = req_amount_1;
            amt[2] = req_amount_2;
            amt[3] = req_amount_3;
            want = predict_allocation(req_op, req_process, amt);
            if (req_op == bsa_pkg::OP_REQUEST && want.status == bsa_pkg::ST_OK)
               granted_seen <= granted_seen + 1;
            if (want.status == bsa_pkg::ST_UNSAFE) unsafe_seen <= unsafe_seen + 1;
            expected_q = {expected_q, want};
         end
         pending_count <= expected_q.size();
      end
   end

endmodule

// File: bench/banker_safe_allocation_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banker_safe_allocation_tb: top level of the safe allocation engine bench
// Drives directed and random request beats with random idling and a long
// response stall, and reports the verdict from the checker's error count.
// ----------------------------------------------------------------------------
module banker_safe_allocation_tb;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_op;
   logic [2:0]  req_process;
   logic [7:0]  req_amount_0;
   logic [7:0]  req_amount_1;
   logic [7:0]  req_amount_2;
   logic [7:0]  req_amount_3;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_status;
   logic [23:0] rsp_safe_order;
   logic [3:0]  rsp_order_length;
   int          error_count;
   int          pending_count;
   int          unsafe_seen;
   int          granted_seen;

   // Shared idling controls: the calm window switches off random gaps on both
   // sides, and the hold-off window keeps the receiver stalled.
   logic        calm;
   logic        hold_off;
   int          beats_sent;
   logic        stim_done;

   banker_safe_allocation i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_process      (req_process),
      .req_amount_0     (req_amount_0),
      .req_amount_1     (req_amount_1),
      .req_amount_2     (req_amount_2),
      .req_amount_3     (req_amount_3),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_safe_order   (rsp_safe_order),
      .rsp_order_length (rsp_order_length)
   );

   banker_safe_allocation_chk i_chk (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_process      (req_process),
      .req_amount_0     (req_amount_0),
      .req_amount_1     (req_amount_1),
      .req_amount_2     (req_amount_2),
      .req_amount_3     (req_amount_3),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_safe_order   (rsp_safe_order),
      .rsp_order_length (rsp_order_length),
      .error_count      (error_count),
      .pending_count    (pending_count),
      .unsafe_seen      (unsafe_seen),
      .granted_seen     (granted_seen)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // The receiver takes responses about 70 percent of the time, always in the
   // calm window, and never while the hold-off window is open.
   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= !hold_off && (calm || $urandom_range(99) >= 30);
   end

   // The long receiver stall is counted here in cycles. It opens once the
   // random part is under way, so the engine fills and stops taking beats.
   initial begin
      hold_off = 1'b0;
      wait (beats_sent >= 200);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (600) @(posedge clock);
      hold_off <= 1'b0;
   end

   // Sends one request beat and holds it until the engine takes it. Valid
   // stays high between back-to-back beats, so it is raised here and only
   // lowered for an idle gap.
   task automatic send_beat(input logic [2:0] op, input logic [2:0] pid,
                            input logic [7:0] a0, input logic [7:0] a1,
                            input logic [7:0] a2, input logic [7:0] a3);
      while (!calm && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_op       <= op;
      req_process  <= pid;
      req_amount_0 <= a0;
      req_amount_1 <= a1;
      req_amount_2 <= a2;
      req_amount_3 <= a3;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
   endtask

   // Random amount, usually small so that the tables give safe states, with
   // occasional extremes so that every bit of the amounts toggles.
   function automatic logic [7:0] pick_amount(int top);
      if ($urandom_range(9) == 0) return 8'($urandom);
      return 8'($urandom_range(top));
   endfunction

   // One well-formed scenario: fresh claims and allocations, an available
   // vector, then a few requests and a safety check with random content.
   task automatic run_scenario();
      logic [7:0] m [bsa_pkg::RESOURCES];
      for (int p = 0; p < bsa_pkg::PROCESSES; p++) begin
         for (int r = 0; r < bsa_pkg::RESOURCES; r++) m[r] = pick_amount(12);
         send_beat(bsa_pkg::OP_LOAD_MAX, 3'(p), m[0], m[1], m[2], m[3]);
         send_beat(bsa_pkg::OP_LOAD_ALLOC, 3'(p), 8'($urandom_range(m[0])),
                   8'($urandom_range(m[1])), 8'($urandom_range(m[2])),
                   8'($urandom_range(m[3])));
      end
      send_beat(bsa_pkg::OP_LOAD_AVAIL, 3'($urandom), pick_amount(8), pick_amount(8),
                pick_amount(8), pick_amount(8));
      repeat ($urandom_range(8, 3))
         send_beat(bsa_pkg::OP_REQUEST, 3'($urandom), pick_amount(4), pick_amount(4),
                   pick_amount(4), pick_amount(4));
      send_beat(bsa_pkg::OP_CHECK, 3'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom), 8'($urandom));
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_op       = bsa_pkg::OP_LOAD_MAX;
      req_process  = '0;
      req_amount_0 = '0;
      req_amount_1 = '0;
      req_amount_2 = '0;
      req_amount_3 = '0;
      calm         = 1'b0;
      beats_sent   = 0;
      stim_done    = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. A check of the empty state is safe in index order.
      send_beat(bsa_pkg::OP_CHECK, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      // A request against zero need exceeds it with any non-zero amount.
      send_beat(bsa_pkg::OP_REQUEST, 3'd7, 8'd1, 8'd0, 8'd0, 8'd0);
      send_beat(bsa_pkg::OP_LOAD_MAX, 3'd0, 8'd255, 8'd255, 8'd255, 8'd255);
      send_beat(bsa_pkg::OP_LOAD_MAX, 3'd7, 8'd3, 8'd3, 8'd3, 8'd3);
      send_beat(bsa_pkg::OP_LOAD_AVAIL, 3'd5, 8'd2, 8'd2, 8'd2, 8'd2);
      // Exceeds available but not need, then a grant that is rolled back as unsafe.
      send_beat(bsa_pkg::OP_REQUEST, 3'd0, 8'd3, 8'd0, 8'd0, 8'd0);
      send_beat(bsa_pkg::OP_REQUEST, 3'd7, 8'd1, 8'd1, 8'd1, 8'd1);
      // Now process 0 can never finish: the check stalls with a partial order.
      send_beat(bsa_pkg::OP_CHECK, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      // A grant that leaves the state unsafe is rolled back.
      send_beat(bsa_pkg::OP_REQUEST, 3'd7, 8'd1, 8'd0, 8'd0, 8'd0);
      // Allocation above maximum gives a negative need: it always fits, and
      // any request for that process exceeds it, even a zero one.
      send_beat(bsa_pkg::OP_LOAD_ALLOC, 3'd3, 8'd255, 8'd0, 8'd128, 8'd1);
      send_beat(bsa_pkg::OP_REQUEST, 3'd3, 8'd0, 8'd0, 8'd0, 8'd0);
      send_beat(bsa_pkg::OP_LOAD_MAX, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      send_beat(bsa_pkg::OP_CHECK, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      // Unused op codes are ignored.
      send_beat(3'd5, 3'd1, 8'hAA, 8'h55, 8'hFF, 8'h00);
      send_beat(3'd6, 3'd6, 8'h55, 8'hAA, 8'h00, 8'hFF);
      send_beat(3'd7, 3'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_beat(bsa_pkg::OP_LOAD_AVAIL, 3'd0, 8'd255, 8'd255, 8'd255, 8'd255);
      send_beat(bsa_pkg::OP_CHECK, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0);

      // Random part: mostly full scenarios, with the calm window in the
      // middle, and about a fifth of the rounds as short bursts of unconstrained noise.
      while (beats_sent < 530) begin
         calm = (beats_sent >= 350 && beats_sent < 430);
         if ($urandom_range(4) == 0)
            repeat ($urandom_range(6, 1))
               send_beat(3'($urandom), 3'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom));
         else
            run_scenario();
      end
      calm = 1'b0;
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   // Waits until no response is still expected, then reports the verdict from the error count.
   initial begin
      wait (stim_done);
      while (pending_count != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("Sent %0d beats: %0d granted requests, %0d unsafe outcomes.",
               beats_sent, granted_seen, unsafe_seen);
      $display("Covered loads, requests, checks, unused codes and a long response stall.");
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Watchdog sized for every beat taking a full scan plus idling and stalls.
   initial begin
      #5ms;
      $display("Timeout with %0d responses still expected.", pending_count);
      $display("== FAIL ==");
      $finish;
   end

endmodule
